>>> src/hmlp_pkg.sv
package hmlp_pkg;

	localparam int KEY_W = 20;
	localparam int VAL_W = 20;
	localparam int OP_W  = 2;
	localparam int TAG_W = 2;
	localparam int ST_W  = 2;

	localparam logic [OP_W-1:0] OP_PUT    = 2'd0;
	localparam logic [OP_W-1:0] OP_GET    = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
	localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

	localparam logic [TAG_W-1:0] TAG_EMPTY = 2'd0;
	localparam logic [TAG_W-1:0] TAG_USED  = 2'd1;
	localparam logic [TAG_W-1:0] TAG_TOMB  = 2'd2;

	localparam logic [ST_W-1:0] ST_OK   = 2'd0;
	localparam logic [ST_W-1:0] ST_MISS = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic             tag_en;
		logic             key_en;
		logic             val_en;
		logic [TAG_W-1:0] tag;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] val;
	} slot_wr_t;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] val;
	} slot_rd_t;

endpackage

>>> src/hmlp_req_if.sv
interface hmlp_req_if import hmlp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  opcode;
	logic [KEY_W-1:0] lookup_key;
	logic [VAL_W-1:0] put_value;

	modport source (output valid, output opcode, output lookup_key, output put_value,
		input ready);
	modport sink (input valid, input opcode, input lookup_key, input put_value,
		output ready);
endinterface

>>> src/hmlp_rsp_if.sv
interface hmlp_rsp_if import hmlp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             found;
	logic [VAL_W-1:0] read_value;
	logic [ST_W-1:0]  status;

	modport source (output valid, output found, output read_value, output status,
		input ready);
	modport sink (input valid, input found, input read_value, input status,
		output ready);
endinterface

>>> src/hmlp_mod_unit.sv
module hmlp_mod_unit import hmlp_pkg::*; #(
	parameter int TABLE_SIZE = 1024
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       start,
	input  logic [KEY_W-1:0]                           key,
	output logic                                       done,
	output logic [((TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1)-1:0] rem
);

	localparam int IDX_W  = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam int PROD_W = 2 * KEY_W;
	// The reciprocal is scaled by 2^KEY_W, so the quotient taken from it is at most
	// one short and a single compare and subtract finishes the remainder.
	localparam logic [KEY_W-1:0] RECIP   = KEY_W'((1 << KEY_W) / TABLE_SIZE);
	localparam logic [KEY_W-1:0] DIVISOR = KEY_W'(TABLE_SIZE);

	localparam logic [1:0] STEP_QUOT = 2'd0;
	localparam logic [1:0] STEP_DIFF = 2'd1;
	localparam logic [1:0] STEP_FIX  = 2'd2;

	logic              busy_q;
	logic              done_q;
	logic [1:0]        step_q;
	logic [KEY_W-1:0]  key_q;
	logic [KEY_W-1:0]  quot_q;
	logic [KEY_W-1:0]  diff_q;
	logic [IDX_W-1:0]  rem_q;

	logic [KEY_W-1:0]  mul_a;
	logic [KEY_W-1:0]  mul_b;
	logic [PROD_W-1:0] prod;
	logic [KEY_W-1:0]  diff_fix;

	// One multiplier serves both the quotient estimate and the product of the
	// quotient with the table size.
	always_comb begin
		mul_a    = (step_q == STEP_QUOT) ? key_q : quot_q;
		mul_b    = (step_q == STEP_QUOT) ? RECIP : DIVISOR;
		prod     = PROD_W'(mul_a) * PROD_W'(mul_b);
		diff_fix = (diff_q >= DIVISOR) ? diff_q - DIVISOR : diff_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= STEP_QUOT;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_QUOT;
			end else if (busy_q) begin
				if (step_q == STEP_FIX) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					step_q <= STEP_QUOT;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			key_q <= key;
		end else if (busy_q) begin
			unique case (step_q)
				STEP_QUOT: begin
					quot_q <= prod[PROD_W-1:KEY_W];
				end
				STEP_DIFF: begin
					diff_q <= key_q - prod[KEY_W-1:0];
				end
				default: begin
					rem_q <= diff_fix[IDX_W-1:0];
				end
			endcase
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

>>> src/hmlp_slot_mem.sv
module hmlp_slot_mem import hmlp_pkg::*; #(
	parameter int TABLE_SIZE = 1024
) (
	input  logic                                                   clk,
	input  logic [((TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1)-1:0] wr_addr,
	input  slot_wr_t                                               wr,
	input  logic [((TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1)-1:0] rd_addr,
	output slot_rd_t                                               rd
);

	logic [TAG_W-1:0] tag_mem [TABLE_SIZE];
	logic [KEY_W-1:0] key_mem [TABLE_SIZE];
	logic [VAL_W-1:0] val_mem [TABLE_SIZE];

	always_ff @(posedge clk) begin
		if (wr.tag_en) begin
			tag_mem[wr_addr] <= wr.tag;
		end
		if (wr.key_en) begin
			key_mem[wr_addr] <= wr.key;
		end
		if (wr.val_en) begin
			val_mem[wr_addr] <= wr.val;
		end
	end

	always_ff @(posedge clk) begin
		rd.tag <= tag_mem[rd_addr];
		rd.key <= key_mem[rd_addr];
		rd.val <= val_mem[rd_addr];
	end

endmodule

>>> src/hash_map_linear_probe_top.sv
// An accepted word's key is reduced to a home slot (directly for a power-of-two
// TABLE_SIZE, else by the remainder unit's quotient, difference and fix steps) and p
// slots are probed, p from 1 to TABLE_SIZE, one slot-memory read per cycle; a no-op
// goes straight to its result. One operation at a time; the next word is taken the
// cycle after the result is registered.
// After reset the tags are cleared with ready low; keys and values are not.
module hash_map_linear_probe_top import hmlp_pkg::*; #(
	parameter int TABLE_SIZE = 1024
) (
	input logic         clk,
	input logic         arst_n,
	hmlp_req_if.sink    req,
	hmlp_rsp_if.source  rsp
);

	localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam int CNT_W = IDX_W + 1;
	localparam bit IS_POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TABLE_SIZE - 1);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_MOD   = 3'd2;
	localparam logic [2:0] S_READ  = 3'd3;
	localparam logic [2:0] S_CHECK = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0]       state_q;
	logic [IDX_W-1:0] pos_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] free_q;
	logic             have_free_q;
	logic             rsp_valid_q;

	logic [OP_W-1:0]  op_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;
	logic             res_found_q;
	logic [VAL_W-1:0] res_value_q;
	logic [ST_W-1:0]  res_status_q;
	logic             rsp_found_q;
	logic [VAL_W-1:0] rsp_value_q;
	logic [ST_W-1:0]  rsp_status_q;

	logic             accept;
	logic             mod_start;
	logic             mod_done;
	logic [IDX_W-1:0] mod_rem;
	logic [IDX_W-1:0] pos_next;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] wr_addr;
	slot_wr_t         wr;
	slot_rd_t         rd;
	logic             is_empty;
	logic             key_hit;
	logic             probe_end;
	logic             eff_have;
	logic [IDX_W-1:0] eff_free;
	logic             out_load;
	logic [VAL_W-1:0] res_value;
	logic [ST_W-1:0]  res_status;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign mod_start = accept && (req.opcode != OP_NOP) && !IS_POW2;
	assign out_load  = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);

	hmlp_mod_unit #(.TABLE_SIZE(TABLE_SIZE)) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.key    (req.lookup_key),
		.done   (mod_done),
		.rem    (mod_rem)
	);

	hmlp_slot_mem #(.TABLE_SIZE(TABLE_SIZE)) u_mem (
		.clk     (clk),
		.wr_addr (wr_addr),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd      (rd)
	);

	// While probing, the next slot's address goes out early so that one slot is
	// checked every cycle.
	always_comb begin
		pos_next  = (pos_q == LAST_IDX) ? '0 : pos_q + 1'b1;
		rd_addr   = (state_q == S_CHECK) ? pos_next : pos_q;
		is_empty  = (rd.tag == TAG_EMPTY);
		key_hit   = (rd.tag == TAG_USED) && (rd.key == key_q);
		probe_end = is_empty || key_hit || (cnt_q == LAST_CNT);
		eff_have  = have_free_q || (rd.tag != TAG_USED);
		eff_free  = have_free_q ? free_q : pos_q;
	end

	always_comb begin
		res_value  = '0;
		res_status = ST_OK;
		if (key_hit) begin
			if (op_q == OP_GET) begin
				res_value = rd.val;
			end
		end else if (op_q == OP_PUT) begin
			res_status = eff_have ? ST_OK : ST_FULL;
		end else begin
			res_status = ST_MISS;
		end
	end

	always_comb begin
		wr      = '0;
		wr_addr = pos_q;
		if (state_q == S_CLEAR) begin
			wr.tag_en = 1'b1;
			wr.tag    = TAG_EMPTY;
		end else if ((state_q == S_CHECK) && probe_end) begin
			unique case (op_q)
				OP_PUT: begin
					if (key_hit) begin
						wr.val_en = 1'b1;
						wr.val    = val_q;
					end else if (eff_have) begin
						wr_addr   = eff_free;
						wr.tag_en = 1'b1;
						wr.key_en = 1'b1;
						wr.val_en = 1'b1;
						wr.tag    = TAG_USED;
						wr.key    = key_q;
						wr.val    = val_q;
					end
				end
				OP_REMOVE: begin
					if (key_hit) begin
						wr.tag_en = 1'b1;
						wr.tag    = TAG_TOMB;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			pos_q       <= '0;
			cnt_q       <= '0;
			free_q      <= '0;
			have_free_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					pos_q <= pos_next;
					if (pos_q == LAST_IDX) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						cnt_q       <= '0;
						have_free_q <= 1'b0;
						if (req.opcode == OP_NOP) begin
							state_q <= S_DONE;
						end else if (IS_POW2) begin
							pos_q   <= req.lookup_key[IDX_W-1:0];
							state_q <= S_READ;
						end else begin
							state_q <= S_MOD;
						end
					end
				end
				S_MOD: begin
					if (mod_done) begin
						pos_q   <= mod_rem;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (probe_end) begin
						state_q <= S_DONE;
					end else begin
						pos_q <= pos_next;
						cnt_q <= cnt_q + 1'b1;
						if (!have_free_q && (rd.tag != TAG_USED)) begin
							have_free_q <= 1'b1;
							free_q      <= pos_q;
						end
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q         <= req.opcode;
			key_q        <= req.lookup_key;
			val_q        <= req.put_value;
			res_found_q  <= 1'b0;
			res_value_q  <= '0;
			res_status_q <= ST_OK;
		end else if ((state_q == S_CHECK) && probe_end) begin
			res_found_q  <= key_hit;
			res_value_q  <= res_value;
			res_status_q <= res_status;
		end
		if (out_load) begin
			rsp_found_q  <= res_found_q;
			rsp_value_q  <= res_value_q;
			rsp_status_q <= res_status_q;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.found      = rsp_found_q;
	assign rsp.read_value = rsp_value_q;
	assign rsp.status     = rsp_status_q;

	a_write_only_when_owned: assert property (@(posedge clk) disable iff (!arst_n)
		(wr.tag_en || wr.key_en || wr.val_en) |-> (state_q == S_CHECK || state_q == S_CLEAR))
		else $error("slot memory written outside a probe end or the clearing pass");

	a_probe_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK) |-> (cnt_q <= LAST_CNT))
		else $error("probe ran past a full cycle of the table");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("sequencer stayed idle after taking a word");

	a_value_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.read_value != '0)) |-> (rsp.found && rsp.status == ST_OK))
		else $error("read value returned without a key hit");

	a_full_is_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == ST_FULL) |-> !rsp.found)
		else $error("table full reported on a key that was present");

endmodule

>>> tb/sv/testbench.sv
module testbench;
	import hmlp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TBL       = 1024;
	localparam int KEY_MAX   = 1000000;
	localparam int VAL_MAX   = 1000000;
	localparam int MAX_GAP   = 14;
	localparam int IDLE_LIM  = 20000;
	localparam int DRAIN_CYC = TBL + 100;
	localparam int MIX_OPS   = 100;
	localparam int FULL_OPS  = 40;

	typedef struct packed {
		logic             found;
		logic [VAL_W-1:0] read_value;
		logic [ST_W-1:0]  status;
	} op_result_t;

	logic clk;
	logic arst_n;

	hmlp_req_if req_ch ();
	hmlp_rsp_if rsp_ch ();

	hash_map_linear_probe_top #(
		.TABLE_SIZE(TBL)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Mirror of the slot memories, updated as each word is sent.
	logic [TAG_W-1:0] mirror_tag [TBL];
	logic [KEY_W-1:0] mirror_key [TBL];
	logic [VAL_W-1:0] mirror_val [TBL];

	op_result_t expected_rsp [$];
	int         err_cnt;
	int         idle_cycles;
	bit         req_quiet;
	bit         rsp_quiet;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic op_result_t apply_op(input logic [OP_W-1:0] op,
		input logic [KEY_W-1:0] key, input logic [VAL_W-1:0] val);
		op_result_t r;
		int pos;
		int hit;
		int free_pos;
		int n;
		bit hit_ok;
		bit have_free;
		bit stop;
		r = '0;
		if (op == OP_NOP) begin
			return r;
		end
		pos = int'(key) % TBL;
		hit = 0;
		free_pos = 0;
		hit_ok = 1'b0;
		have_free = 1'b0;
		stop = 1'b0;
		// A probe that meets no empty slot stops after one full lap.
		for (n = 0; n < TBL && !stop; n++) begin
			if (mirror_tag[pos] == TAG_EMPTY) begin
				if (!have_free) begin
					have_free = 1'b1;
					free_pos = pos;
				end
				stop = 1'b1;
			end else if (mirror_tag[pos] == TAG_USED) begin
				if (mirror_key[pos] == key) begin
					hit_ok = 1'b1;
					hit = pos;
					stop = 1'b1;
				end
			end else if (!have_free) begin
				have_free = 1'b1;
				free_pos = pos;
			end
			if (!stop) begin
				pos = (pos + 1) % TBL;
			end
		end
		r.found = hit_ok;
		case (op)
			OP_PUT: begin
				if (hit_ok) begin
					mirror_val[hit] = val;
				end else if (have_free) begin
					mirror_tag[free_pos] = TAG_USED;
					mirror_key[free_pos] = key;
					mirror_val[free_pos] = val;
				end else begin
					r.status = ST_FULL;
				end
			end
			OP_GET: begin
				if (hit_ok) begin
					r.read_value = mirror_val[hit];
				end else begin
					r.status = ST_MISS;
				end
			end
			default: begin
				if (hit_ok) begin
					mirror_tag[hit] = TAG_TOMB;
				end else begin
					r.status = ST_MISS;
				end
			end
		endcase
		return r;
	endfunction

	function automatic bit key_stored(input logic [KEY_W-1:0] key);
		foreach (mirror_tag[i]) begin
			if (mirror_tag[i] == TAG_USED && mirror_key[i] == key) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic logic [KEY_W-1:0] key_with_home(input int home);
		int mult;
		mult = $urandom_range(0, (KEY_MAX - home) / TBL);
		return KEY_W'(home + TBL * mult);
	endfunction

	function automatic logic [KEY_W-1:0] absent_key();
		logic [KEY_W-1:0] k;
		k = KEY_W'($urandom_range(0, KEY_MAX));
		while (key_stored(k)) begin
			k = KEY_W'($urandom_range(0, KEY_MAX));
		end
		return k;
	endfunction

	function automatic logic [KEY_W-1:0] stored_key();
		int s;
		s = $urandom_range(0, TBL - 1);
		while (mirror_tag[s] != TAG_USED) begin
			s = (s + 1) % TBL;
		end
		return mirror_key[s];
	endfunction

	function automatic int draw_gap(input bit quiet);
		if (quiet) begin
			return 0;
		end
		return $urandom_range(0, MAX_GAP);
	endfunction

	// Sends one request word; returns right after the edge that accepts it.
	task automatic send_op(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
		input logic [VAL_W-1:0] val);
		int gap;
		if ($urandom_range(0, 29) == 0) begin
			req_quiet = ~req_quiet;
		end
		gap = draw_gap(req_quiet);
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.opcode     <= op;
		req_ch.lookup_key <= key;
		req_ch.put_value  <= val;
		expected_rsp.push_back(apply_op(op, key, val));
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic test_basic_ops();
		send_op(OP_GET, 20'd5, 20'd0);
		send_op(OP_PUT, 20'd5, 20'd111);
		send_op(OP_GET, 20'd5, 20'd0);
		send_op(OP_PUT, 20'd5, 20'd222);
		send_op(OP_GET, 20'd5, 20'd7);
		send_op(OP_REMOVE, 20'd5, 20'd0);
		send_op(OP_GET, 20'd5, 20'd0);
		send_op(OP_REMOVE, 20'd5, 20'd0);
		send_op(OP_NOP, 20'd5, 20'd9);
	endtask

	// A put must find its key past a tombstone rather than reuse the tombstone.
	task automatic test_tombstone_probe();
		send_op(OP_PUT, 20'd100, 20'd1);
		send_op(OP_PUT, 20'd1124, 20'd2);
		send_op(OP_PUT, 20'd2148, 20'd3);
		send_op(OP_REMOVE, 20'd1124, 20'd0);
		send_op(OP_PUT, 20'd2148, 20'd33);
		send_op(OP_GET, 20'd2148, 20'd0);
		send_op(OP_PUT, 20'd1124, 20'd22);
		send_op(OP_GET, 20'd1124, 20'd0);
	endtask

	task automatic test_wraparound();
		send_op(OP_PUT, 20'd1023, 20'd44);
		send_op(OP_PUT, 20'd2047, 20'd55);
		send_op(OP_GET, 20'd2047, 20'd0);
	endtask

	task automatic test_extremes();
		send_op(OP_PUT, 20'd0, VAL_W'(VAL_MAX));
		send_op(OP_PUT, KEY_W'(KEY_MAX), 20'd0);
		send_op(OP_GET, 20'd0, 20'd0);
		send_op(OP_GET, KEY_W'(KEY_MAX), VAL_W'(VAL_MAX));
		send_op(OP_NOP, KEY_W'(KEY_MAX), VAL_W'(VAL_MAX));
	endtask

	// Keys crowd into two small groups of home slots, one of them across the
	// end of the table, so that chains, tombstones and updates come up often.
	task automatic test_random_mix();
		logic [KEY_W-1:0] pool [48];
		logic [KEY_W-1:0] key;
		logic [OP_W-1:0]  op;
		int base;
		int r;
		base = $urandom_range(0, 900);
		foreach (pool[i]) begin
			if (i < 24) begin
				pool[i] = key_with_home(base + $urandom_range(0, 15));
			end else begin
				pool[i] = key_with_home((TBL - 8 + $urandom_range(0, 15)) % TBL);
			end
		end
		repeat (MIX_OPS) begin
			r = $urandom_range(0, 99);
			if (r < 75) begin
				key = pool[$urandom_range(0, 47)];
			end else if (r < 95) begin
				key = KEY_W'($urandom_range(0, KEY_MAX));
			end else begin
				key = ($urandom_range(0, 1) != 0) ? KEY_W'(KEY_MAX) : '0;
			end
			r = $urandom_range(0, 99);
			if (r < 40) begin
				op = OP_PUT;
			end else if (r < 70) begin
				op = OP_GET;
			end else if (r < 95) begin
				op = OP_REMOVE;
			end else begin
				op = OP_NOP;
			end
			send_op(op, key, VAL_W'($urandom_range(0, VAL_MAX)));
		end
	endtask

	// Every slot that is not occupied gets a fresh key whose home is that slot.
	task automatic test_fill_table();
		logic [KEY_W-1:0] key;
		for (int s = 0; s < TBL; s++) begin
			if (mirror_tag[s] != TAG_USED) begin
				key = key_with_home(s);
				while (key_stored(key)) begin
					key = key_with_home(s);
				end
				send_op(OP_PUT, key, VAL_W'($urandom_range(0, VAL_MAX)));
			end
		end
	endtask

	// With no empty slot left, every miss runs a full lap of the table, and a
	// new key can only land in a tombstone left by a remove.
	task automatic test_full_table();
		logic [KEY_W-1:0] key;
		logic [OP_W-1:0]  op;
		int r;
		repeat (FULL_OPS) begin
			r = $urandom_range(0, 99);
			if (r < 30) begin
				op = OP_PUT;
				key = absent_key();
			end else if (r < 45) begin
				op = OP_PUT;
				key = stored_key();
			end else if (r < 60) begin
				op = OP_GET;
				key = stored_key();
			end else if (r < 70) begin
				op = OP_GET;
				key = absent_key();
			end else if (r < 90) begin
				op = OP_REMOVE;
				key = stored_key();
			end else if (r < 95) begin
				op = OP_REMOVE;
				key = absent_key();
			end else begin
				op = OP_NOP;
				key = absent_key();
			end
			send_op(op, key, VAL_W'($urandom_range(0, VAL_MAX)));
		end
	endtask

	initial begin
		foreach (mirror_tag[i]) begin
			mirror_tag[i] = TAG_EMPTY;
			mirror_key[i] = '0;
			mirror_val[i] = '0;
		end
		err_cnt = 0;
		req_quiet = 1'b0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_NOP;
		req_ch.lookup_key = '0;
		req_ch.put_value = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_basic_ops();
		test_tombstone_probe();
		test_wraparound();
		test_extremes();
		test_random_mix();
		test_fill_table();
		test_full_table();

		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (expected_rsp.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		if (err_cnt == 0) begin
			$display("hash_map_linear_probe_top verification clean");
		end else begin
			$display("hash_map_linear_probe_top verification failed");
		end
		$finish;
	end

	// Result side: random stalls on ready, then a field-by-field compare.
	initial begin
		op_result_t want;
		int stall;
		rsp_quiet = 1'b0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 29) == 0) begin
				rsp_quiet = ~rsp_quiet;
			end
			stall = draw_gap(rsp_quiet);
			@(negedge clk);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			if (expected_rsp.size() == 0) begin
				$error("result word with no request outstanding");
				err_cnt++;
			end else begin
				want = expected_rsp.pop_front();
				if (rsp_ch.found !== want.found) begin
					$error("found: expected %0d, got %0d", want.found, rsp_ch.found);
					err_cnt++;
				end
				if (rsp_ch.read_value !== want.read_value) begin
					$error("read_value: expected %0d, got %0d", want.read_value,
						rsp_ch.read_value);
					err_cnt++;
				end
				if (rsp_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
					err_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIM) begin
			$display("hash_map_linear_probe_top verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

>>> files.f
src/hmlp_pkg.sv
src/hmlp_req_if.sv
src/hmlp_rsp_if.sv
src/hmlp_mod_unit.sv
src/hmlp_slot_mem.sv
src/hash_map_linear_probe_top.sv
tb/sv/testbench.sv
